// ===== rtl/lpfr_pkg.sv =====
// Shared types and constants for the length-prefixed frame receiver.
package lpfr_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 1'b1;

    // Register reset values
    localparam logic [7:0] START_MARKER_RST = 8'd2;
    localparam logic [7:0] END_MARKER_RST   = 8'd3;

    // Input channel item
    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } item_t;

    // Output channel item
    typedef struct packed {
        logic [7:0] payload_byte;
        logic [4:0] byte_position;
        logic [5:0] frame_length;
        logic       last;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_fill;
        logic load_len;
        logic write_byte;
        logic clear_rd;
        logic read_byte;
        logic next_rd;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic start_hit;
        logic len_ok;
        logic fill_done;
        logic end_hit;
        logic emit_last;
    } dp_status_t;

endpackage

// ===== rtl/lpfr_dp.sv =====
// Datapath: marker registers, length and fill counters, payload buffer, result fields.
module lpfr_dp #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lpfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                      cfg_data,
    input  logic [7:0]                      rx_byte,
    input  lpfr_pkg::dp_cmd_t               cmd,
    output lpfr_pkg::dp_status_t            status,
    output lpfr_pkg::result_t               result_data
);

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0]       start_marker_reg;
    logic [7:0]       end_marker_reg;
    logic [LEN_W-1:0] expected_len_reg;
    logic [LEN_W-1:0] fill_reg;
    logic [LEN_W-1:0] fill_next;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [7:0]       rd_data_reg;
    logic [7:0]       payload_mem [0:MAX_PAYLOAD-1];
    logic [6:0]       pos_wide;
    logic [6:0]       len_wide;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= lpfr_pkg::START_MARKER_RST;
            end_marker_reg   <= lpfr_pkg::END_MARKER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lpfr_pkg::REG_START_MARKER: start_marker_reg <= cfg_data;
                lpfr_pkg::REG_END_MARKER:   end_marker_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign fill_next = fill_reg + LEN_W'(1);

    // Frame length and fill / read counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_len_reg <= '0;
            fill_reg         <= '0;
            rd_idx_reg       <= '0;
        end
        else
        begin
            if (cmd.load_len)
                expected_len_reg <= rx_byte[LEN_W-1:0];
            if (cmd.clear_fill)
                fill_reg <= '0;
            else if (cmd.write_byte)
                fill_reg <= fill_next;
            if (cmd.clear_rd)
                rd_idx_reg <= '0;
            else if (cmd.next_rd)
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
        end
    end

    // Payload buffer, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.write_byte)
            payload_mem[fill_reg[IDX_W-1:0]] <= rx_byte;
        if (cmd.read_byte)
            rd_data_reg <= payload_mem[rd_idx_reg];
    end

    // Status back to the controller
    assign status.start_hit = (rx_byte == start_marker_reg);
    assign status.end_hit   = (rx_byte == end_marker_reg);
    assign status.len_ok    = (rx_byte != 8'd0) && ({1'b0, rx_byte} <= 9'(MAX_PAYLOAD));
    assign status.fill_done = (fill_next >= expected_len_reg);
    assign status.emit_last = ((LEN_W'(rd_idx_reg) + LEN_W'(1)) == expected_len_reg);

    // Result fields, trimmed to the port widths
    assign pos_wide = 7'(rd_idx_reg);
    assign len_wide = 7'(expected_len_reg);

    assign result_data.payload_byte  = rd_data_reg;
    assign result_data.byte_position = pos_wide[4:0];
    assign result_data.frame_length  = len_wide[5:0];
    assign result_data.last          = status.emit_last;

endmodule

// ===== rtl/lpfr_ctrl.sv =====
// Controller: frame parsing state machine and result burst sequencing.
module lpfr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  action,
    input  logic                  result_stall,
    input  lpfr_pkg::dp_status_t  status,
    output logic                  item_stall,
    output logic                  result_valid,
    output lpfr_pkg::dp_cmd_t     cmd
);

    localparam logic [2:0] ST_HUNT  = 3'd0;
    localparam logic [2:0] ST_LEN   = 3'd1;
    localparam logic [2:0] ST_DATA  = 3'd2;
    localparam logic [2:0] ST_ENDM  = 3'd3;
    localparam logic [2:0] ST_FETCH = 3'd4;
    localparam logic [2:0] ST_SEND  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       busy;
    logic       item_acc;

    // Input is held off while a burst is being read out
    assign busy         = (state_reg == ST_FETCH) || (state_reg == ST_SEND);
    assign item_stall   = busy;
    assign result_valid = (state_reg == ST_SEND);
    assign item_acc     = item_valid && !busy;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        if (item_acc && action)
        begin
            state_next     = ST_HUNT;
            cmd.clear_fill = 1'b1;
        end
        else
        begin
            unique case (state_reg)
                ST_HUNT:
                begin
                    if (item_acc && status.start_hit)
                    begin
                        state_next     = ST_LEN;
                        cmd.clear_fill = 1'b1;
                    end
                end
                ST_LEN:
                begin
                    if (item_acc)
                    begin
                        if (status.len_ok)
                        begin
                            state_next     = ST_DATA;
                            cmd.load_len   = 1'b1;
                            cmd.clear_fill = 1'b1;
                        end
                        else
                            state_next = ST_HUNT;
                    end
                end
                ST_DATA:
                begin
                    if (item_acc)
                    begin
                        cmd.write_byte = 1'b1;
                        if (status.fill_done)
                            state_next = ST_ENDM;
                    end
                end
                ST_ENDM:
                begin
                    if (item_acc)
                    begin
                        if (status.end_hit)
                        begin
                            state_next   = ST_FETCH;
                            cmd.clear_rd = 1'b1;
                        end
                        else
                            state_next = ST_HUNT;
                    end
                end
                ST_FETCH:
                begin
                    cmd.read_byte = 1'b1;
                    state_next    = ST_SEND;
                end
                ST_SEND:
                begin
                    if (!result_stall)
                    begin
                        if (status.emit_last)
                            state_next = ST_HUNT;
                        else
                        begin
                            cmd.next_rd = 1'b1;
                            state_next  = ST_FETCH;
                        end
                    end
                end
                default: state_next = ST_HUNT;
            endcase
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_HUNT;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/length_prefixed_frame_receiver.sv =====
// Top level of the length-prefixed frame receiver.
// Usage:
//   The item channel (item_valid / item_stall / item_data) carries one received
//   byte per request, or a reset action that returns the receiver to hunting.
//   A frame is start marker, length (1..MAX_PAYLOAD), payload, end marker.
//   Frames with a bad length or a wrong closing byte are dropped silently.
//   When the end marker arrives, the stored payload leaves on the result
//   channel (result_valid / result_stall / result_data), one request per
//   byte, with last set on the final one.
// Sequencing:
//   The parser takes input bytes whenever no burst is being read out. After
//   the end marker is accepted, the controller first reads the buffer in
//   ST_FETCH and result_valid rises in ST_SEND; each result takes one buffer
//   read and one output state, and item_stall stays high for the whole burst,
//   including any time result_stall is held. The controller fetches each buffer
//   byte in the state just before the output state that sends it.
// Reset:
//   rst_n returns the receiver to hunting and the markers to 2 and 3.
//   A stalled result holds its value until it is taken.
module length_prefixed_frame_receiver #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  lpfr_pkg::item_t                 item_data,
    output logic                            result_valid,
    input  logic                            result_stall,
    output lpfr_pkg::result_t               result_data,
    input  logic                            cfg_we,
    input  logic [lpfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                      cfg_data
);

    lpfr_pkg::dp_cmd_t    cmd;
    lpfr_pkg::dp_status_t status;

    // Frame controller
    lpfr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .action       (item_data.action),
        .result_stall (result_stall),
        .status       (status),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .cmd          (cmd)
    );

    // Buffer and counters
    lpfr_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .rx_byte     (item_data.rx_byte),
        .cmd         (cmd),
        .status      (status),
        .result_data (result_data)
    );

endmodule

// ===== rtl/lpfr_checker.sv =====
// Port-level checks for the length-prefixed frame receiver, bound to the top level.
module lpfr_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input lpfr_pkg::result_t result_data
);

    // A stalled result stays put
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("result changed while stalled");

    // No input is taken while a burst is being delivered
    a_stall_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> item_stall)
        else $error("input open during result burst");

    // Positions inside a burst step by one
    a_position_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result_data.last |=> ##1
            result_valid &&
            result_data.byte_position == $past(result_data.byte_position, 2) + 5'd1)
        else $error("byte position did not advance by one");

    // Burst ends after the last byte is taken
    a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && result_data.last |=> !result_valid && !item_stall)
        else $error("burst continued after last byte");

endmodule

bind length_prefixed_frame_receiver lpfr_checker u_lpfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);

// ===== tb/sv/tb_length_prefixed_frame_receiver.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the length-prefixed frame receiver.
module tb_length_prefixed_frame_receiver;

    localparam int PAYLOAD_CAP  = 32;
    localparam int SETTLE_TICKS = 8;
    localparam int CYCLE_LIMIT  = 200000;

    // Receiver parse phases
    typedef enum logic [1:0] {HUNT, AWAIT_LEN, FILL, AWAIT_END} rx_phase_t;

    // One pending request; hold_off makes the sender wait for all results first
    typedef struct {
        lpfr_pkg::item_t req;
        bit              hold_off;
    } pending_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    lpfr_pkg::item_t item_data = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    lpfr_pkg::result_t result_data;
    logic cfg_we = 1'b0;
    logic [lpfr_pkg::CFG_IDX_W-1:0] cfg_index = lpfr_pkg::REG_START_MARKER;
    logic [7:0] cfg_data = 8'd0;

    pending_req_t pending_reqs[$];
    lpfr_pkg::result_t expected_payload[$];
    int requests_queued = 0;
    int requests_accepted = 0;
    int error_count = 0;
    int cycle_count = 0;
    bit item_taken = 1'b0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    // Marker values the stimulus is built for
    logic [7:0] tx_start = lpfr_pkg::START_MARKER_RST;
    logic [7:0] tx_end   = lpfr_pkg::END_MARKER_RST;

    // Predicted receiver state
    logic [7:0] open_marker  = lpfr_pkg::START_MARKER_RST;
    logic [7:0] close_marker = lpfr_pkg::END_MARKER_RST;
    rx_phase_t rx_phase = HUNT;
    int frame_len = 0;
    int fill_count = 0;
    logic [7:0] frame_bytes [PAYLOAD_CAP];

    length_prefixed_frame_receiver #(
        .MAX_PAYLOAD (PAYLOAD_CAP)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Advance the predicted parser by one accepted request
    task automatic deframe_byte(lpfr_pkg::item_t req);
        lpfr_pkg::result_t r;
        if (req.action)
        begin
            rx_phase = HUNT;
            frame_len = 0;
            fill_count = 0;
            return;
        end
        case (rx_phase)
            HUNT:
            begin
                if (req.rx_byte == open_marker)
                begin
                    fill_count = 0;
                    rx_phase = AWAIT_LEN;
                end
            end
            AWAIT_LEN:
            begin
                if (req.rx_byte != 8'd0 && req.rx_byte <= PAYLOAD_CAP)
                begin
                    frame_len = req.rx_byte;
                    fill_count = 0;
                    rx_phase = FILL;
                end
                else
                    rx_phase = HUNT;
            end
            FILL:
            begin
                if (fill_count < PAYLOAD_CAP)
                    frame_bytes[fill_count] = req.rx_byte;
                fill_count++;
                if (fill_count >= frame_len)
                    rx_phase = AWAIT_END;
            end
            default:
            begin
                // Closing byte matches: the whole payload leaves as a burst
                if (req.rx_byte == close_marker)
                begin
                    for (int i = 0; i < frame_len; i++)
                    begin
                        r.payload_byte  = frame_bytes[i];
                        r.byte_position = 5'(i);
                        r.frame_length  = 6'(frame_len);
                        r.last          = (i == frame_len - 1);
                        expected_payload.push_back(r);
                    end
                end
                rx_phase = HUNT;
            end
        endcase
    endtask

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
        end
    endtask

    // Monitor: register writes, accepted requests, accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == lpfr_pkg::REG_START_MARKER)
                    open_marker = cfg_data;
                else if (cfg_index == lpfr_pkg::REG_END_MARKER)
                    close_marker = cfg_data;
            end
            if (result_valid && !result_stall)
            begin
                if (expected_payload.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, got 0x%0h",
                             $time, result_data);
                end
                else
                begin
                    lpfr_pkg::result_t want;
                    want = expected_payload.pop_front();
                    check_field("payload_byte", 32'(want.payload_byte),
                                32'(result_data.payload_byte));
                    check_field("byte_position", 32'(want.byte_position),
                                32'(result_data.byte_position));
                    check_field("frame_length", 32'(want.frame_length),
                                32'(result_data.frame_length));
                    check_field("last", 32'(want.last), 32'(result_data.last));
                end
            end
            if (item_valid && !item_stall)
            begin
                deframe_byte(item_data);
                requests_accepted <= requests_accepted + 1;
            end
            item_taken <= item_valid && !item_stall;
        end
    end

    // Driver: presents pending requests and random result stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            result_stall <= ($urandom_range(99) < stall_pct);
            if (!item_valid || item_taken)
            begin
                if (pending_reqs.size() != 0
                    && !(pending_reqs[0].hold_off && expected_payload.size() != 0)
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    item_data <= pending_reqs[0].req;
                    item_valid <= 1'b1;
                    void'(pending_reqs.pop_front());
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("[length_prefixed_frame_receiver] ERROR");
            $finish;
        end
    end

    task automatic queue_req(bit action, logic [7:0] b, bit hold = 1'b0);
        pending_req_t p;
        p.req.action = action;
        p.req.rx_byte = b;
        p.hold_off = hold;
        pending_reqs.push_back(p);
        requests_queued++;
    endtask

    // Start marker, length, payload, then the end marker or a wrong closing byte
    task automatic queue_frame(int len, bit closed, bit hold = 1'b0);
        logic [7:0] closer;
        queue_req(1'b0, tx_start, hold);
        queue_req(1'b0, 8'(len));
        for (int i = 0; i < len; i++)
            queue_req(1'b0, 8'($urandom_range(255)));
        closer = 8'($urandom_range(255));
        if (closer == tx_end)
            closer = closer ^ 8'h01;
        queue_req(1'b0, closed ? tx_end : closer);
    endtask

    task automatic random_traffic(int target);
        int sent;
        int pick;
        int len;
        int upto;
        logic [7:0] bad_len;
        sent = 0;
        while (sent < target)
        begin
            pick = $urandom_range(99);
            len = ($urandom_range(9) == 0) ? $urandom_range(9, PAYLOAD_CAP)
                                           : $urandom_range(1, 8);
            if ($urandom_range(19) == 0)
                len = PAYLOAD_CAP;
            if (pick < 62)
            begin
                queue_frame(len, 1'b1, $urandom_range(24) == 0);
                sent += len + 3;
            end
            else if (pick < 74)
            begin
                queue_frame(len, 1'b0);
                sent += len + 3;
            end
            else if (pick < 82)
            begin
                // Bad length; a marker that is itself a bad length is a favorite
                case ($urandom_range(3))
                    0: bad_len = 8'd0;
                    1: bad_len = 8'($urandom_range(PAYLOAD_CAP + 1, 255));
                    2: bad_len = (tx_start == 8'd0 || tx_start > PAYLOAD_CAP) ? tx_start
                                                                               : 8'd255;
                    default: bad_len = 8'(PAYLOAD_CAP + 1);
                endcase
                queue_req(1'b0, tx_start);
                queue_req(1'b0, bad_len);
                sent += 2;
            end
            else if (pick < 90)
            begin
                queue_req(1'b0, 8'($urandom_range(255)));
                sent++;
            end
            else
            begin
                // Reset action at a random point of a frame
                queue_req(1'b0, tx_start);
                sent++;
                if ($urandom_range(3) != 0)
                begin
                    len = $urandom_range(1, 8);
                    upto = $urandom_range(0, len);
                    queue_req(1'b0, 8'(len));
                    for (int i = 0; i < upto; i++)
                        queue_req(1'b0, 8'($urandom_range(255)));
                    sent += upto + 1;
                end
                queue_req(1'b1, 8'($urandom_range(255)));
                sent++;
            end
        end
    endtask

    // Wait until every request is taken and every result has come
    task automatic wait_idle();
        @(negedge clk);
        while (requests_accepted != requests_queued || expected_payload.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic write_markers(logic [7:0] start_val, logic [7:0] end_val);
        cfg_we <= 1'b1;
        cfg_index <= lpfr_pkg::REG_START_MARKER;
        cfg_data <= start_val;
        @(negedge clk);
        cfg_index <= lpfr_pkg::REG_END_MARKER;
        cfg_data <= end_val;
        @(negedge clk);
        cfg_we <= 1'b0;
        tx_start = start_val;
        tx_end = end_val;
        @(posedge clk);
    endtask

    // Stimulus sequence
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 6;
        stall_pct = 51;

        // Directed part with the reset markers
        queue_req(1'b0, 8'h00);
        queue_req(1'b0, 8'hFF);
        queue_req(1'b1, 8'hFF);
        queue_req(1'b0, tx_start);
        queue_req(1'b0, 8'd1);
        queue_req(1'b0, 8'hFF);
        queue_req(1'b0, tx_end);
        queue_req(1'b0, tx_start);
        queue_req(1'b0, 8'd2);
        queue_req(1'b0, 8'h00);
        queue_req(1'b0, tx_start);
        queue_req(1'b0, tx_end);
        queue_req(1'b0, tx_start);
        queue_req(1'b0, 8'd0);
        queue_req(1'b0, tx_start);
        queue_req(1'b0, 8'(PAYLOAD_CAP + 1));
        queue_req(1'b0, tx_start);
        queue_req(1'b0, 8'd1);
        queue_req(1'b0, 8'h55);
        queue_req(1'b0, 8'h04);
        queue_req(1'b0, tx_start);
        queue_req(1'b0, 8'd3);
        queue_req(1'b0, 8'hAA);
        queue_req(1'b1, tx_start);
        queue_req(1'b0, tx_end);

        // Sender holds off once until the whole burst is out
        queue_frame(4, 1'b1, 1'b1);
        random_traffic(85);
        wait_idle();

        write_markers(8'h00, 8'hFF);
        random_traffic(85);
        wait_idle();

        send_idle_pct = 51;
        stall_pct = 6;
        write_markers(8'hFF, 8'h00);
        random_traffic(85);
        wait_idle();

        send_idle_pct = 0;
        stall_pct = 0;
        write_markers(8'h7E, 8'h7E);
        queue_frame(PAYLOAD_CAP, 1'b1, 1'b1);
        random_traffic(85);
        wait_idle();
        repeat (4 * PAYLOAD_CAP) @(negedge clk);

        if (error_count == 0)
            $display("[length_prefixed_frame_receiver] OK");
        else
            $display("[length_prefixed_frame_receiver] ERROR");
        $finish;
    end

endmodule

// ===== length_prefixed_frame_receiver.f =====
rtl/lpfr_pkg.sv
rtl/lpfr_dp.sv
rtl/lpfr_ctrl.sv
rtl/length_prefixed_frame_receiver.sv
rtl/lpfr_checker.sv
tb/sv/tb_length_prefixed_frame_receiver.sv
